// ----- hw/rtl/wipn_pkg.sv -----
// ----------------------------------------------------------------------------
// wipn_pkg
// Shared types, constants and arithmetic step functions for the weight image
// pixel normalizer pipeline.
// ----------------------------------------------------------------------------
package wipn_pkg;

  // Fixed-point format
  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int NUM_W     = DATA_W + FRAC_BITS;      // dividend width
  localparam int SQ_STEPS  = (NUM_W + 1) / 2;         // root bits
  localparam int SQ_IN_W   = 2 * SQ_STEPS;            // padded radicand
  localparam int SQ_REM_W  = SQ_STEPS + 2;            // root remainder
  localparam int PROD_W    = DATA_W + SQ_STEPS;       // pixel * root

  localparam logic [DATA_W-1:0] ONE_FX = DATA_W'(1) << FRAC_BITS;

  // Pipeline depth of each iterative section
  localparam int N_DIV  = NUM_W;
  localparam int N_SQRT = SQ_STEPS;

  // Configuration register indexes
  localparam logic CFG_WEIGHT_LIMIT = 1'b0;
  localparam logic CFG_USE_WEIGHT   = 1'b1;

  typedef enum logic [1:0] {
    MODE_NORM_DIV = 2'd0,
    MODE_DIV      = 2'd1,
    MODE_MUL      = 2'd2,
    MODE_PLANE    = 2'd3
  } mode_t;

  // Plane-divide section: pixel and weight dividers side by side
  typedef struct packed {
    mode_t             mode;
    logic [DATA_W-1:0] pix;
    logic              pneg;
    logic              pdo;
    logic              pzero;
    logic [DATA_W-1:0] pmag;
    logic [DATA_W-1:0] pden;
    logic [DATA_W-1:0] prem;
    logic [NUM_W-1:0]  pquo;
    logic              wdo;
    logic              wzero;
    logic [DATA_W-1:0] w;
    logic [DATA_W-1:0] wden;
    logic [DATA_W-1:0] wrem;
    logic [NUM_W-1:0]  wquo;
  } div1_t;

  // Square-root section
  typedef struct packed {
    mode_t               mode;
    logic                act;
    logic                below;
    logic                pdiv;
    logic                sat;
    logic [DATA_W-1:0]   pix1;
    logic                neg;
    logic [DATA_W-1:0]   mag;
    logic [SQ_IN_W-1:0]  rad;
    logic [SQ_REM_W-1:0] rem;
    logic [SQ_STEPS-1:0] root;
  } sqrt_t;

  // Masked divide / multiply section
  typedef struct packed {
    mode_t               mode;
    logic                act;
    logic                below;
    logic                pdiv;
    logic                sat;
    logic [DATA_W-1:0]   pix1;
    logic                neg;
    logic [DATA_W-1:0]   mag;
    logic [SQ_STEPS-1:0] den;
    logic [DATA_W-1:0]   rem;
    logic [NUM_W-1:0]    quo;
    logic [PROD_W-1:0]   prod;
  } div2_t;

  // One restoring division step: returns {quotient bit, new remainder}
  function automatic logic [DATA_W:0] div_step(input logic [DATA_W-1:0] rem,
                                               input logic nbit,
                                               input logic [DATA_W-1:0] den);
    logic [DATA_W:0] rs;
    logic [DATA_W:0] diff;
    rs   = {rem, nbit};
    diff = rs - {1'b0, den};
    if (rs >= {1'b0, den}) begin
      return {1'b1, diff[DATA_W-1:0]};
    end
    return {1'b0, rs[DATA_W-1:0]};
  endfunction

  // One digit-by-digit square root step: returns {new root, new remainder}
  function automatic logic [SQ_STEPS+SQ_REM_W-1:0] sqrt_step(
      input logic [SQ_REM_W-1:0] rem,
      input logic [SQ_STEPS-1:0] root,
      input logic [1:0]          two);
    logic [SQ_REM_W+1:0] rs;
    logic [SQ_REM_W+1:0] trial;
    logic [SQ_REM_W+1:0] diff;
    rs    = {rem, two};
    trial = (SQ_REM_W+2)'({root, 2'b01});
    diff  = rs - trial;
    if (rs >= trial) begin
      return {root[SQ_STEPS-2:0], 1'b1, diff[SQ_REM_W-1:0]};
    end
    return {root[SQ_STEPS-2:0], 1'b0, rs[SQ_REM_W-1:0]};
  endfunction

  // Sign + magnitude to saturated two's complement: returns {sat, value}
  function automatic logic [DATA_W:0] pack_signed(input logic neg,
                                                  input logic [NUM_W-1:0] mag);
    logic [NUM_W-1:0]  max_p;
    logic [NUM_W-1:0]  max_n;
    logic [NUM_W-1:0]  m;
    logic              sat;
    max_p = NUM_W'({1'b0, {(DATA_W-1){1'b1}}});
    max_n = NUM_W'({1'b1, {(DATA_W-1){1'b0}}});
    m     = mag;
    sat   = 1'b0;
    if (neg) begin
      if (m > max_n) begin
        m   = max_n;
        sat = 1'b1;
      end
      return {sat, DATA_W'(0) - m[DATA_W-1:0]};
    end
    if (m > max_p) begin
      m   = max_p;
      sat = 1'b1;
    end
    return {sat, m[DATA_W-1:0]};
  endfunction

endpackage

// ----- hw/rtl/weight_image_pixel_normalizer_core.sv -----
// ----------------------------------------------------------------------------
// weight_image_pixel_normalizer_core
// Streaming Q16.16 pixel normalizer: plane-sum divide, then masked divide or
// multiply by the square root of the weight, fully pipelined.
// ----------------------------------------------------------------------------
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  in      | in_valid/in_ready, mode, pixel, weight, | input
//          | pixel and weight plane sums             |
//  out     | out_valid/out_ready, result and flags   | output
//  cfg     | cfg_wr_en, cfg_index, cfg_wdata         | input
//
//  One transaction per cycle sustained while out_ready does not stall; at Q16.16
//  the pipeline depth is set mainly by the two bit-per-stage dividers and the
//  two-bits-per-stage square root.
//  Synchronous active-low reset clears the valid bits and the config registers.
//  A stall on out_ready freezes the whole pipeline; nothing is dropped.
// ----------------------------------------------------------------------------
module weight_image_pixel_normalizer_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic                         cfg_index,
  input  logic [wipn_pkg::DATA_W-1:0]  cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   in_mode,
  input  logic signed [31:0]           in_pixel_value,
  input  logic [31:0]                  in_weight_value,
  input  logic [31:0]                  in_pixel_plane_sum,
  input  logic [31:0]                  in_weight_plane_sum,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [31:0]           out_result_value,
  output logic                         out_below_limit,
  output logic                         out_plane_divided,
  output logic                         out_saturated
);
  import wipn_pkg::*;

  logic              en;
  logic [DATA_W-1:0] weight_limit_r;
  logic              use_weight_r;

  div1_t s1_r [0:N_DIV];
  logic  v1_r [0:N_DIV];
  sqrt_t s2_r [0:N_SQRT];
  logic  v2_r [0:N_SQRT];
  div2_t s3_r [0:N_DIV];
  logic  v3_r [0:N_DIV];

  logic              out_valid_r;
  logic [DATA_W-1:0] out_result_r;
  logic              out_below_r;
  logic              out_pdiv_r;
  logic              out_sat_r;

  // Global advance: output empty or being taken
  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weight_limit_r <= '0;
      use_weight_r   <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_WEIGHT_LIMIT: weight_limit_r <= cfg_wdata;
        CFG_USE_WEIGHT:   use_weight_r   <= cfg_wdata[0];
        default:          ;
      endcase
    end
  end

  // Entry stage: decode mode, split pixel into sign and magnitude
  div1_t entry_nxt;
  always_comb begin
    entry_nxt       = '0;
    entry_nxt.mode  = mode_t'(in_mode);
    entry_nxt.pix   = in_pixel_value;
    entry_nxt.pneg  = in_pixel_value[DATA_W-1];
    entry_nxt.pmag  = entry_nxt.pneg ? DATA_W'(0) - in_pixel_value : in_pixel_value;
    entry_nxt.pdo   = (entry_nxt.mode == MODE_NORM_DIV || entry_nxt.mode == MODE_PLANE)
                      && (in_pixel_plane_sum != ONE_FX);
    entry_nxt.pzero = (in_pixel_plane_sum == '0) && (entry_nxt.pmag == '0);
    entry_nxt.pden  = in_pixel_plane_sum;
    entry_nxt.wdo   = (entry_nxt.mode == MODE_NORM_DIV) && use_weight_r
                      && (in_weight_plane_sum != ONE_FX);
    entry_nxt.wzero = (in_weight_plane_sum == '0) && (in_weight_value == '0);
    entry_nxt.w     = in_weight_value;
    entry_nxt.wden  = in_weight_plane_sum;
  end

  always_ff @(posedge clk) begin
    if (en) s1_r[0] <= entry_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r[0] <= 1'b0;
    end else if (en) begin
      v1_r[0] <= in_valid;
    end
  end

  // Plane-sum dividers, one quotient bit per stage
  for (genvar gi = 0; gi < N_DIV; gi++) begin : g_div1
    logic [NUM_W-1:0] pnum;
    logic [NUM_W-1:0] wnum;
    logic [DATA_W:0]  pst;
    logic [DATA_W:0]  wst;
    div1_t            stage_nxt;
    assign pnum = {s1_r[gi].pmag, {FRAC_BITS{1'b0}}};
    assign wnum = {s1_r[gi].w, {FRAC_BITS{1'b0}}};
    assign pst  = div_step(s1_r[gi].prem, pnum[NUM_W-1-gi], s1_r[gi].pden);
    assign wst  = div_step(s1_r[gi].wrem, wnum[NUM_W-1-gi], s1_r[gi].wden);

    always_comb begin
      stage_nxt      = s1_r[gi];
      stage_nxt.prem = pst[DATA_W-1:0];
      stage_nxt.pquo = {s1_r[gi].pquo[NUM_W-2:0], pst[DATA_W]};
      stage_nxt.wrem = wst[DATA_W-1:0];
      stage_nxt.wquo = {s1_r[gi].wquo[NUM_W-2:0], wst[DATA_W]};
    end

    always_ff @(posedge clk) begin
      if (en) s1_r[gi+1] <= stage_nxt;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v1_r[gi+1] <= 1'b0;
      end else if (en) begin
        v1_r[gi+1] <= v1_r[gi];
      end
    end
  end

  // Resolve stage: saturate divided pixel and weight, apply the limit
  sqrt_t            res_nxt;
  div1_t            d1;
  logic [NUM_W-1:0] pq;
  logic [NUM_W-1:0] wq;
  logic [DATA_W:0]  ppk;
  logic [DATA_W-1:0] w1;
  logic             wsat;
  logic             wact;
  logic             pass;
  always_comb begin
    d1      = s1_r[N_DIV];
    res_nxt = '0;
    pq      = d1.pzero ? '0 : d1.pquo;
    wq      = d1.wzero ? '0 : d1.wquo;
    ppk     = pack_signed(d1.pneg, pq);
    wsat    = 1'b0;
    w1      = d1.w;
    if (d1.wdo) begin
      if (wq > NUM_W'({DATA_W{1'b1}})) begin
        w1   = '1;
        wsat = 1'b1;
      end else begin
        w1 = wq[DATA_W-1:0];
      end
    end
    wact          = (d1.mode != MODE_PLANE) && use_weight_r;
    pass          = w1 > weight_limit_r;
    res_nxt.mode  = d1.mode;
    res_nxt.pdiv  = d1.pdo;
    res_nxt.pix1  = d1.pdo ? ppk[DATA_W-1:0] : d1.pix;
    res_nxt.sat   = (d1.pdo && ppk[DATA_W]) || wsat;
    res_nxt.act   = wact && pass;
    res_nxt.below = wact && !pass;
    res_nxt.neg   = res_nxt.pix1[DATA_W-1];
    res_nxt.mag   = res_nxt.neg ? DATA_W'(0) - res_nxt.pix1 : res_nxt.pix1;
    res_nxt.rad   = SQ_IN_W'({w1, {FRAC_BITS{1'b0}}});
  end

  always_ff @(posedge clk) begin
    if (en) s2_r[0] <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r[0] <= 1'b0;
    end else if (en) begin
      v2_r[0] <= v1_r[N_DIV];
    end
  end

  // Square root of the weight, one root bit per stage
  for (genvar gi = 0; gi < N_SQRT; gi++) begin : g_sqrt
    logic [SQ_STEPS+SQ_REM_W-1:0] sst;
    sqrt_t                        stage_nxt;
    assign sst = sqrt_step(s2_r[gi].rem, s2_r[gi].root,
                           s2_r[gi].rad[SQ_IN_W-1-2*gi -: 2]);

    always_comb begin
      stage_nxt      = s2_r[gi];
      stage_nxt.rem  = sst[SQ_REM_W-1:0];
      stage_nxt.root = sst[SQ_STEPS+SQ_REM_W-1:SQ_REM_W];
    end

    always_ff @(posedge clk) begin
      if (en) s2_r[gi+1] <= stage_nxt;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v2_r[gi+1] <= 1'b0;
      end else if (en) begin
        v2_r[gi+1] <= v2_r[gi];
      end
    end
  end

  // Masked-step entry: product for the multiply mode, divider setup
  div2_t m_nxt;
  always_comb begin
    m_nxt       = '0;
    m_nxt.mode  = s2_r[N_SQRT].mode;
    m_nxt.act   = s2_r[N_SQRT].act;
    m_nxt.below = s2_r[N_SQRT].below;
    m_nxt.pdiv  = s2_r[N_SQRT].pdiv;
    m_nxt.sat   = s2_r[N_SQRT].sat;
    m_nxt.pix1  = s2_r[N_SQRT].pix1;
    m_nxt.neg   = s2_r[N_SQRT].neg;
    m_nxt.mag   = s2_r[N_SQRT].mag;
    m_nxt.den   = s2_r[N_SQRT].root;
    m_nxt.prod  = PROD_W'(s2_r[N_SQRT].mag) * PROD_W'(s2_r[N_SQRT].root);
  end

  always_ff @(posedge clk) begin
    if (en) s3_r[0] <= m_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r[0] <= 1'b0;
    end else if (en) begin
      v3_r[0] <= v2_r[N_SQRT];
    end
  end

  // Pixel divided by root, one quotient bit per stage
  for (genvar gi = 0; gi < N_DIV; gi++) begin : g_div2
    logic [NUM_W-1:0] num;
    logic [DATA_W:0]  qst;
    div2_t            stage_nxt;
    assign num = {s3_r[gi].mag, {FRAC_BITS{1'b0}}};
    assign qst = div_step(s3_r[gi].rem, num[NUM_W-1-gi], DATA_W'(s3_r[gi].den));

    always_comb begin
      stage_nxt     = s3_r[gi];
      stage_nxt.rem = qst[DATA_W-1:0];
      stage_nxt.quo = {s3_r[gi].quo[NUM_W-2:0], qst[DATA_W]};
    end

    always_ff @(posedge clk) begin
      if (en) s3_r[gi+1] <= stage_nxt;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v3_r[gi+1] <= 1'b0;
      end else if (en) begin
        v3_r[gi+1] <= v3_r[gi];
      end
    end
  end

  // Final pack and output register
  div2_t            d3;
  logic [NUM_W-1:0] fmag;
  logic [DATA_W:0]  fpk;
  logic [DATA_W-1:0] res_val_nxt;
  logic             res_sat_nxt;
  always_comb begin
    d3          = s3_r[N_DIV];
    fmag        = (d3.mode == MODE_MUL) ? NUM_W'(d3.prod >> FRAC_BITS) : d3.quo;
    fpk         = pack_signed(d3.neg, fmag);
    res_sat_nxt = d3.sat;
    if (d3.act) begin
      res_val_nxt = fpk[DATA_W-1:0];
      res_sat_nxt = d3.sat || fpk[DATA_W];
    end else if (d3.below) begin
      res_val_nxt = '0;
    end else begin
      res_val_nxt = d3.pix1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_result_r <= res_val_nxt;
      out_below_r  <= d3.below;
      out_pdiv_r   <= d3.pdiv;
      out_sat_r    <= res_sat_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= v3_r[N_DIV];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_result_value  = out_result_r;
  assign out_below_limit   = out_below_r;
  assign out_plane_divided = out_pdiv_r;
  assign out_saturated     = out_sat_r;

  // A zeroed transaction always reports a zero result
  a_below_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_below_limit |-> out_result_value == '0)
    else $error("below_limit with nonzero result");

  // A weight above the limit always yields a nonzero root
  a_root_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r[N_DIV] && s3_r[N_DIV].act |-> s3_r[N_DIV].den != '0)
    else $error("masked step with zero root");

  // Plane division only happens in the normalizing modes
  a_pdiv_mode: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r[N_DIV] && s3_r[N_DIV].pdiv |->
      (s3_r[N_DIV].mode == MODE_NORM_DIV || s3_r[N_DIV].mode == MODE_PLANE))
    else $error("plane divide in wrong mode");

  // Masked step and zeroing never apply together
  a_act_below: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r[0] |-> !(s2_r[0].act && s2_r[0].below))
    else $error("act and below both set");

endmodule

// ----- tb/weight_image_pixel_normalizer_core_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// weight_image_pixel_normalizer_core_test
// Self-checking bench for the pixel normalizer. A directed table covers
// extremes, every mode and the zero-sum, weight-saturation and weights-off
// cases. Random phases then run under changing register settings and
// handshake idling. Each result is checked against its typed table value or an in-bench predictor.
// ----------------------------------------------------------------------------
module weight_image_pixel_normalizer_core_test;
  import wipn_pkg::*;

  localparam int DRAIN_CYCLES = 2 * NUM_W + SQ_STEPS + 10;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int RAND_ITEMS   = 1400;
  localparam int NUM_PHASES   = 8;

  typedef struct {
    mode_t       mode;
    logic [31:0] pix;
    logic [31:0] w;
    logic [31:0] psum;
    logic [31:0] wsum;
  } pixel_item_t;

  typedef struct {
    logic [31:0] value;
    logic        below;
    logic        pdiv;
    logic        sat;
  } norm_result_t;

  typedef struct {
    logic [31:0]  limit;
    logic         use_w;
    pixel_item_t  item;
    logic         typed;
    norm_result_t res;
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic        cfg_index;
  logic [31:0] cfg_wdata;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_mode;
  logic signed [31:0] in_pixel_value;
  logic [31:0] in_weight_value;
  logic [31:0] in_pixel_plane_sum;
  logic [31:0] in_weight_plane_sum;
  logic        out_valid;
  logic        out_ready;
  logic signed [31:0] out_result_value;
  logic        out_below_limit;
  logic        out_plane_divided;
  logic        out_saturated;

  // shadow copy of the block's registers
  logic [31:0] cur_limit;
  logic        cur_use_w;

  norm_result_t pending_q[$];
  dir_row_t     dir_tab[$];
  int           send_idle_pct;
  int           recv_stall_pct;
  int           fail_count;
  int           cycle_count;

  weight_image_pixel_normalizer_core u_dut (.*);

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------- predictor ----------------
  function automatic logic [31:0] sat_pack(input logic neg, input logic [63:0] mag,
                                           inout logic sat);
    if (mag == 0) return 32'd0;
    if (neg) begin
      if (mag > 64'h8000_0000) begin
        mag = 64'h8000_0000;
        sat = 1'b1;
      end
      return 32'(64'h1_0000_0000 - mag);
    end
    if (mag > 64'h7FFF_FFFF) begin
      mag = 64'h7FFF_FFFF;
      sat = 1'b1;
    end
    return mag[31:0];
  endfunction

  function automatic logic [63:0] quot_by_sum(input logic [63:0] mag, input logic [31:0] sum);
    if (sum == 0) return (mag != 0) ? 64'hFF_FFFF_FFFF : 64'd0;
    return (mag << FRAC_BITS) / {32'd0, sum};
  endfunction

  function automatic logic [63:0] int_root(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] t;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  function automatic norm_result_t predict_pixel(input pixel_item_t it);
    norm_result_t r;
    logic [31:0]  p;
    logic [63:0]  wv;
    logic [63:0]  mag;
    logic [63:0]  s;
    logic         neg;
    p = it.pix;
    wv = {32'd0, it.w};
    r = '{value: 32'd0, below: 1'b0, pdiv: 1'b0, sat: 1'b0};
    // plane-sum divide
    if ((it.mode == MODE_NORM_DIV || it.mode == MODE_PLANE) && it.psum != ONE_FX) begin
      neg = p[31];
      mag = neg ? 64'h1_0000_0000 - {32'd0, p} : {32'd0, p};
      p = sat_pack(neg, quot_by_sum(mag, it.psum), r.sat);
      r.pdiv = 1'b1;
    end
    // masked divide / multiply by sqrt(weight)
    if (it.mode != MODE_PLANE && cur_use_w) begin
      if (it.mode == MODE_NORM_DIV && it.wsum != ONE_FX) begin
        wv = quot_by_sum(wv, it.wsum);
        if (wv > 64'hFFFF_FFFF) begin
          wv = 64'hFFFF_FFFF;
          r.sat = 1'b1;
        end
      end
      if (wv > {32'd0, cur_limit}) begin
        s = int_root(wv << FRAC_BITS);
        neg = p[31];
        mag = neg ? 64'h1_0000_0000 - {32'd0, p} : {32'd0, p};
        if (it.mode == MODE_MUL) mag = (mag * s) >> FRAC_BITS;
        else mag = (mag << FRAC_BITS) / s;
        p = sat_pack(neg, mag, r.sat);
      end else begin
        p = 32'd0;
        r.below = 1'b1;
      end
    end
    r.value = p;
    return r;
  endfunction

  // ---------------- stimulus helpers ----------------
  function automatic void add_row(input logic [31:0] limit, input logic use_w, input mode_t m,
                                  input logic [31:0] pix, input logic [31:0] w,
                                  input logic [31:0] psum, input logic [31:0] wsum,
                                  input logic typed, input logic [31:0] val,
                                  input logic below, input logic pdiv, input logic sat);
    dir_row_t row;
    row.limit = limit;
    row.use_w = use_w;
    row.item  = '{mode: m, pix: pix, w: w, psum: psum, wsum: wsum};
    row.typed = typed;
    row.res   = '{value: val, below: below, pdiv: pdiv, sat: sat};
    dir_tab.push_back(row);
  endfunction

  // write both registers once the pipeline is empty
  task automatic set_regs(input logic [31:0] limit, input logic use_w);
    wait (pending_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_WEIGHT_LIMIT;
    cfg_wdata <= limit;
    @(posedge clk);
    cfg_index <= CFG_USE_WEIGHT;
    cfg_wdata <= {31'd0, use_w};
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_limit = limit;
    cur_use_w = use_w;
  endtask

  // drive one transaction and record its expected result on acceptance
  task automatic send_pixel(input pixel_item_t it, input logic typed, input norm_result_t res);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid            <= 1'b1;
    in_mode             <= it.mode;
    in_pixel_value      <= it.pix;
    in_weight_value     <= it.w;
    in_pixel_plane_sum  <= it.psum;
    in_weight_plane_sum <= it.wsum;
    do @(posedge clk); while (!in_ready);
    pending_q.push_back(typed ? res : predict_pixel(it));
  endtask

  function automatic logic [31:0] pick_sum();
    case ($urandom_range(5))
      0, 1:    return ONE_FX;
      2:       return $urandom_range(32'h8000, 32'h40000);
      3:       return $urandom_range(1, 16);
      4:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_pixel();
    case ($urandom_range(5))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return $urandom_range(0, 32'h40000);
      3:       return -$urandom_range(0, 32'h40000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_weight();
    case ($urandom_range(4))
      0:       return cur_limit + $urandom_range(0, 3) - 1;
      1:       return $urandom_range(0, 32'h80000);
      2:       return 32'hFFFF_FFFF - $urandom_range(0, 7);
      default: return $urandom;
    endcase
  endfunction

  // ---------------- result checking ----------------
  always @(posedge clk) begin
    norm_result_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_q.size() == 0) begin
        $error("result transaction with nothing expected: value %h", out_result_value);
        fail_count++;
      end else begin
        e = pending_q.pop_front();
        if (out_result_value !== e.value) begin
          $error("result_value exp %h got %h", e.value, out_result_value);
          fail_count++;
        end
        if (out_below_limit !== e.below) begin
          $error("below_limit exp %b got %b", e.below, out_below_limit);
          fail_count++;
        end
        if (out_plane_divided !== e.pdiv) begin
          $error("plane_divided exp %b got %b", e.pdiv, out_plane_divided);
          fail_count++;
        end
        if (out_saturated !== e.sat) begin
          $error("saturated exp %b got %b", e.sat, out_saturated);
          fail_count++;
        end
      end
    end
  end

  // receiver backpressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------- main sequence ----------------
  initial begin
    pixel_item_t  it;
    norm_result_t dummy;
    logic [31:0]  lim;
    int           per_phase;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = CFG_WEIGHT_LIMIT;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_mode = MODE_NORM_DIV;
    in_pixel_value = '0;
    in_weight_value = '0;
    in_pixel_plane_sum = ONE_FX;
    in_weight_plane_sum = ONE_FX;
    out_ready = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    fail_count = 0;
    cycle_count = 0;
    cur_limit = '0;
    cur_use_w = 1'b0;
    dummy = '{value: 32'd0, below: 1'b0, pdiv: 1'b0, sat: 1'b0};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table; first rows run on reset register values
    add_row(0, 0, MODE_DIV,   32'h8000_0000, 5, ONE_FX, ONE_FX, 1, 32'h8000_0000, 0, 0, 0);
    add_row(0, 0, MODE_MUL,   32'h7FFF_FFFF, 0, 3, 7, 1, 32'h7FFF_FFFF, 0, 0, 0);
    add_row(0, 0, MODE_PLANE, 32'h1234_5678, 0, ONE_FX, 0, 1, 32'h1234_5678, 0, 0, 0);
    add_row(0, 0, MODE_PLANE, 32'd5, 0, 0, ONE_FX, 1, 32'h7FFF_FFFF, 0, 1, 1);
    add_row(0, 0, MODE_PLANE, 32'd0, 0, 0, ONE_FX, 1, 32'd0, 0, 1, 0);
    add_row(0, 0, MODE_PLANE, 32'hFFFF_FFFF, 0, 0, ONE_FX, 1, 32'h8000_0000, 0, 1, 1);
    add_row(0, 0, MODE_NORM_DIV, 32'h7FFF_FFFF, 9, 1, 1, 1, 32'h7FFF_FFFF, 0, 1, 1);
    add_row(0, 0, MODE_NORM_DIV, 32'h8000_0000, 9, 32'h20000, 1, 0, 0, 0, 0, 0);
    add_row(32'h10000, 1, MODE_DIV, 32'h10000, 32'h10000, ONE_FX, ONE_FX, 1, 0, 1, 0, 0);
    add_row(32'h10000, 1, MODE_MUL, 32'h7FFF_FFFF, 0, ONE_FX, ONE_FX, 1, 0, 1, 0, 0);
    add_row(32'h10000, 1, MODE_DIV, 32'h10000, 32'h40000, ONE_FX, ONE_FX, 0, 0, 0, 0, 0);
    add_row(32'h10000, 1, MODE_MUL, 32'h8000_0000, 32'hFFFF_FFFF, 1, 1, 0, 0, 0, 0, 0);
    add_row(32'h10000, 1, MODE_NORM_DIV, 32'h30000, 5, ONE_FX, 0, 0, 0, 0, 0, 0);
    add_row(32'h10000, 1, MODE_NORM_DIV, 32'd0, 0, 0, 0, 1, 0, 1, 1, 0);
    add_row(32'h10000, 1, MODE_PLANE, 32'h7FFF_FFFF, 7, 32'h8000, 1, 0, 0, 0, 0, 0);
    add_row(32'h10000, 1, MODE_DIV, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1, 1, 0, 0, 0, 0, 0);
    add_row(32'hFFFF_FFFF, 1, MODE_DIV, 32'h1000, 32'hFFFF_FFFF, 1, 1, 1, 0, 1, 0, 0);
    add_row(32'hFFFF_FFFF, 1, MODE_NORM_DIV, 32'h1000, 32'hFFFF_FFFF, 2, 1, 0, 0, 0, 0, 0);
    add_row(0, 1, MODE_MUL, 32'h7FFF_FFFF, 1, 1, 1, 0, 0, 0, 0, 0);
    add_row(0, 1, MODE_DIV, 32'h8000_0000, 1, 1, 1, 0, 0, 0, 0, 0);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].limit !== cur_limit || dir_tab[i].use_w !== cur_use_w) begin
        in_valid <= 1'b0;
        set_regs(dir_tab[i].limit, dir_tab[i].use_w);
      end
      send_pixel(dir_tab[i].item, dir_tab[i].typed, dir_tab[i].res);
    end
    in_valid <= 1'b0;

    // random phases, each setting its registers and idling pattern
    per_phase = RAND_ITEMS / NUM_PHASES;
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0:       lim = 32'd0;
        1:       lim = 32'hFFFF_FFFF;
        2:       lim = 32'h10000;
        3:       lim = $urandom_range(0, 32'h4000);
        default: lim = $urandom_range(0, 32'h100000);
      endcase
      in_valid <= 1'b0;
      set_regs(lim, (ph % 5) != 4);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
        default: begin send_idle_pct = 22; recv_stall_pct = 22; end
      endcase
      for (int n = 0; n < per_phase; n++) begin
        // hold off once until the pipeline has emptied
        if (ph == 2 && n == per_phase / 2) begin
          in_valid <= 1'b0;
          wait (pending_q.size() == 0);
          @(posedge clk);
        end
        it.mode = mode_t'($urandom_range(3));
        it.pix  = pick_pixel();
        it.w    = pick_weight();
        it.psum = pick_sum();
        it.wsum = pick_sum();
        send_pixel(it, 1'b0, dummy);
      end
    end
    in_valid <= 1'b0;

    wait (pending_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
